FILE: design/kfc_pkg.sv
// Shared types, constants and key table for the keypad calculator.
package kfc_pkg;

    localparam int KFC_MAX_DIGITS = 9;
    localparam int RES_W  = 32;
    localparam int OPND_W = 30;
    localparam int CNT_W  = 4;

    localparam logic [RES_W-1:0] MATCH_RESET = 32'd30;

    typedef enum logic [2:0] {
        OP_NONE = 3'd0,
        OP_ADD  = 3'd1,
        OP_SUB  = 3'd2,
        OP_MUL  = 3'd3,
        OP_DIV  = 3'd4
    } op_t;

    localparam logic [7:0] KC_CLEAR  = 8'hA0;
    localparam logic [7:0] KC_EQUALS = 8'hBD;
    localparam logic [7:0] KC_ADD    = 8'hAB;
    localparam logic [7:0] KC_SUB    = 8'hAD;
    localparam logic [7:0] KC_MUL    = 8'hAA;
    localparam logic [7:0] KC_DIV    = 8'hAF;
    localparam logic [7:0] KC_OPMASK = 8'h0F;

    localparam logic [7:0] KEY_CODES [16] = '{
        8'hB1, 8'hB2, 8'hB3, 8'hAB, 8'hB4, 8'hB5, 8'hB6, 8'hAD,
        8'hB7, 8'hB8, 8'hB9, 8'hAA, 8'hA0, 8'hB0, 8'hBD, 8'hAF
    };

    typedef enum logic [2:0] {
        KEY_NONE,
        KEY_DIGIT,
        KEY_OPER,
        KEY_CLEAR,
        KEY_EQUALS
    } key_kind_t;

    typedef struct packed {
        logic       hit;
        logic [7:0] code;
        key_kind_t  kind;
        op_t        op;
        logic [3:0] digit;
    } key_t;

    typedef struct packed {
        logic start;
        op_t  op;
    } alu_cmd_t;

    typedef struct packed {
        logic done;
        logic div_zero;
    } alu_stat_t;

    typedef struct packed {
        logic              key_hit;
        logic [7:0]        key_code;
        logic              cleared;
        logic              result_valid;
        logic [RES_W-1:0]  result_value;
        logic              divide_error;
        logic              lamp_on;
    } res_word_t;

endpackage

FILE: design/kfc_intf.sv
// Channel interfaces: keypad scan words, result words and match-value writes.
interface kfc_scan_if;
    logic       valid;
    logic       ready;
    logic [1:0] column;
    logic [3:0] row_lines;

    modport source (output valid, output column, output row_lines, input ready);
    modport sink   (input valid, input column, input row_lines, output ready);
endinterface

interface kfc_result_if;
    logic               valid;
    logic               ready;
    logic               key_hit;
    logic [7:0]         key_code;
    logic               cleared;
    logic               result_valid;
    logic signed [31:0] result_value;
    logic               divide_error;
    logic               lamp_on;

    modport source (output valid, output key_hit, output key_code, output cleared,
                    output result_valid, output result_value, output divide_error,
                    output lamp_on, input ready);
    modport sink   (input valid, input key_hit, input key_code, input cleared,
                    input result_valid, input result_value, input divide_error,
                    input lamp_on, output ready);
endinterface

interface kfc_cfg_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: design/kfc_keydec.sv
// Keypad decoder: column and active-low row nibble to key code and key class.
module kfc_keydec (
    input  logic [1:0]    column,
    input  logic [3:0]    row_lines,
    output kfc_pkg::key_t key
);
    import kfc_pkg::*;

    logic       row_ok;
    logic [1:0] row_sel;
    logic [3:0] idx;
    logic [7:0] code;

    always_comb
    begin
        row_ok  = 1'b1;
        row_sel = 2'd0;
        case (row_lines)
            4'hE: row_sel = 2'd3;
            4'hD: row_sel = 2'd2;
            4'hB: row_sel = 2'd1;
            4'h7: row_sel = 2'd0;
            default: row_ok = 1'b0;
        endcase

        // column n drives key position 3-n within the row
        idx  = {row_sel, ~column};
        code = KEY_CODES[idx];

        key       = '0;
        key.kind  = KEY_NONE;
        key.op    = OP_NONE;
        if (row_ok)
        begin
            key.hit   = 1'b1;
            key.code  = code;
            key.digit = code[3:0];
            if (code == KC_CLEAR)
                key.kind = KEY_CLEAR;
            else if ((code | KC_OPMASK) == KC_DIV)
            begin
                key.kind = KEY_OPER;
                case (code)
                    KC_ADD:  key.op = OP_ADD;
                    KC_SUB:  key.op = OP_SUB;
                    KC_MUL:  key.op = OP_MUL;
                    default: key.op = OP_DIV;
                endcase
            end
            else if (code == KC_EQUALS)
                key.kind = KEY_EQUALS;
            else
                key.kind = KEY_DIGIT;
        end
    end

endmodule

FILE: design/kfc_alu.sv
// Bit-serial arithmetic unit: add/sub one bit a cycle, shift-add multiply,
// restoring divide; every operation makes one pass over all RES_W result bits.
module kfc_alu (
    input  logic                        clk,
    input  logic                        rst_n,
    input  kfc_pkg::alu_cmd_t           cmd,
    input  logic [kfc_pkg::OPND_W-1:0]  opnd_a,
    input  logic [kfc_pkg::OPND_W-1:0]  opnd_b,
    output kfc_pkg::alu_stat_t          stat,
    output logic [kfc_pkg::RES_W-1:0]   res
);
    import kfc_pkg::*;

    localparam int StepW = $clog2(RES_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic             dz_reg, dz_next;
    logic             carry_reg, carry_next;
    op_t              op_reg, op_next;
    logic [StepW-1:0] step_reg, step_next;
    logic [RES_W-1:0] a_reg, a_next;
    logic [RES_W-1:0] b_reg, b_next;
    logic [RES_W-1:0] acc_reg, acc_next;
    logic [RES_W-1:0] rem_sh;
    logic [RES_W:0]   diff;
    logic             sum_bit;

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        dz_next    = dz_reg;
        carry_next = carry_reg;
        op_next    = op_reg;
        step_next  = step_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        acc_next   = acc_reg;

        // divide: acc holds the partial remainder, a shifts dividend out, quotient in
        rem_sh  = {acc_reg[RES_W-2:0], a_reg[RES_W-1]};
        diff    = {1'b0, rem_sh} - {1'b0, b_reg};
        sum_bit = a_reg[0] ^ b_reg[0] ^ carry_reg;

        if (cmd.start)
        begin
            busy_next  = 1'b1;
            op_next    = cmd.op;
            step_next  = '0;
            a_next     = RES_W'(opnd_a);
            // subtract as a + ~b + 1
            b_next     = (cmd.op == OP_SUB) ? ~RES_W'(opnd_b) : RES_W'(opnd_b);
            acc_next   = '0;
            carry_next = (cmd.op == OP_SUB);
            dz_next    = (cmd.op == OP_DIV) && (opnd_b == '0);
        end
        else if (busy_reg)
        begin
            case (op_reg)
                OP_ADD, OP_SUB:
                begin
                    acc_next   = {sum_bit, acc_reg[RES_W-1:1]};
                    carry_next = (a_reg[0] & b_reg[0]) | (a_reg[0] & carry_reg)
                               | (b_reg[0] & carry_reg);
                    a_next     = a_reg >> 1;
                    b_next     = b_reg >> 1;
                end
                OP_MUL:
                begin
                    if (b_reg[0])
                        acc_next = acc_reg + a_reg;
                    a_next = a_reg << 1;
                    b_next = b_reg >> 1;
                end
                OP_DIV:
                begin
                    if (!diff[RES_W])
                    begin
                        acc_next = diff[RES_W-1:0];
                        a_next   = {a_reg[RES_W-2:0], 1'b1};
                    end
                    else
                    begin
                        acc_next = rem_sh;
                        a_next   = {a_reg[RES_W-2:0], 1'b0};
                    end
                end
                default: acc_next = acc_reg;
            endcase
            step_next = step_reg + 1'b1;
            if (step_reg == StepW'(RES_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            dz_reg    <= 1'b0;
            carry_reg <= 1'b0;
            op_reg    <= OP_NONE;
            step_reg  <= '0;
            a_reg     <= '0;
            b_reg     <= '0;
            acc_reg   <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            dz_reg    <= dz_next;
            carry_reg <= carry_next;
            op_reg    <= op_next;
            step_reg  <= step_next;
            a_reg     <= a_next;
            b_reg     <= b_next;
            acc_reg   <= acc_next;
        end
    end

    assign res           = (op_reg == OP_DIV) ? a_reg : acc_reg;
    assign stat.done     = done_reg;
    assign stat.div_zero = dz_reg;

endmodule

FILE: design/keypad_four_function_calculator.sv
// Top level of the keypad four-function calculator.
//
//   channel | dir | handshake     | word
//   --------+-----+---------------+-------------------------------------------
//   scan    | in  | valid/ready   | column, row_lines
//   result  | out | valid/ready   | key_hit .. lamp_on, one word per scan word
//   cfg     | in  | valid/ready   | match_value (ready tied high)
//
// Digit, operator, clear, no-key and equals-without-operator words are
// registered in the pending stage on acceptance, then move to the output stage.
// Equals with an operator first runs the bit-serial unit over all 32 result
// bits; its word then takes the same path through the pending and output stages.
// One result word can wait in the output stage while the next scan word is
// accepted; a second completed word holds off scan.ready until the output drains.
// rst_n is asynchronous: operands, operator, last result and lamp clear,
// match_value returns to 30.
module keypad_four_function_calculator #(
    parameter int MAX_DIGITS = kfc_pkg::KFC_MAX_DIGITS
) (
    input  logic           clk,
    input  logic           rst_n,
    kfc_scan_if.sink       scan,
    kfc_result_if.source   result,
    kfc_cfg_if.sink        cfg
);
    import kfc_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_CALC
    } state_t;

    state_t            state_reg, state_next;
    logic [OPND_W-1:0] first_reg, first_next;
    logic [OPND_W-1:0] second_reg, second_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    op_t               oper_reg, oper_next;
    logic [RES_W-1:0]  last_reg, last_next;
    logic [RES_W-1:0]  match_reg, match_next;
    logic              lamp_reg, lamp_next;
    logic              pend_valid_reg, pend_valid_next;
    res_word_t         pend_reg, pend_next;
    logic              out_valid_reg, out_valid_next;
    res_word_t         out_reg, out_next;

    key_t              key;
    alu_cmd_t          cmd;
    alu_stat_t         stat;
    logic [RES_W-1:0]  alu_res;
    logic [RES_W-1:0]  calc_val;
    logic [OPND_W-1:0] opnd_sel;
    logic [OPND_W-1:0] opnd_grown;
    logic              take;
    logic              emit;
    logic              w_hit;
    logic [7:0]        w_code;
    logic              w_cleared;
    logic              w_valid;
    logic              w_derr;

    kfc_keydec u_keydec (
        .column    (scan.column),
        .row_lines (scan.row_lines),
        .key       (key)
    );

    kfc_alu u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .opnd_a (first_reg),
        .opnd_b (second_reg),
        .stat   (stat),
        .res    (alu_res)
    );

    assign scan.ready = (state_reg == ST_IDLE) && !pend_valid_reg;
    assign take       = scan.valid && scan.ready;
    assign cfg.ready  = 1'b1;

    always_comb
    begin
        state_next      = state_reg;
        first_next      = first_reg;
        second_next     = second_reg;
        count_next      = count_reg;
        oper_next       = oper_reg;
        last_next       = last_reg;
        lamp_next       = lamp_reg;
        match_next      = cfg.valid ? RES_W'(cfg.data) : match_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;

        cmd.start = 1'b0;
        cmd.op    = oper_reg;
        emit      = 1'b0;
        w_hit     = 1'b0;
        w_code    = 8'd0;
        w_cleared = 1'b0;
        w_valid   = 1'b0;
        w_derr    = 1'b0;

        calc_val   = stat.div_zero ? '0 : alu_res;
        opnd_sel   = (oper_reg == OP_NONE) ? first_reg : second_reg;
        // x*10 + d as x*8 + x*2 + d
        opnd_grown = OPND_W'({opnd_sel, 3'b000}) + OPND_W'({opnd_sel, 1'b0})
                   + OPND_W'(key.digit);

        // output stage drains, pending word moves up
        if (out_valid_reg && result.ready)
            out_valid_next = 1'b0;
        if (pend_valid_reg && (!out_valid_reg || result.ready))
        begin
            out_valid_next  = 1'b1;
            out_next        = pend_reg;
            pend_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    emit   = 1'b1;
                    w_hit  = key.hit;
                    w_code = key.code;
                    case (key.kind)
                        KEY_CLEAR:
                        begin
                            w_cleared   = 1'b1;
                            first_next  = '0;
                            second_next = '0;
                            count_next  = '0;
                            oper_next   = OP_NONE;
                            last_next   = '0;
                        end
                        KEY_OPER:
                        begin
                            oper_next   = key.op;
                            second_next = '0;
                            count_next  = '0;
                        end
                        KEY_EQUALS:
                        begin
                            if (oper_reg == OP_NONE)
                            begin
                                w_valid   = 1'b1;
                                lamp_next = lamp_reg || (last_reg == match_reg);
                            end
                            else
                            begin
                                emit       = 1'b0;
                                cmd.start  = 1'b1;
                                state_next = ST_CALC;
                            end
                        end
                        KEY_DIGIT:
                        begin
                            if (count_reg < CNT_W'(MAX_DIGITS))
                            begin
                                if (oper_reg == OP_NONE)
                                    first_next = opnd_grown;
                                else
                                    second_next = opnd_grown;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        default: emit = 1'b1;
                    endcase
                end
            end
            ST_CALC:
            begin
                if (stat.done)
                begin
                    emit       = 1'b1;
                    w_hit      = 1'b1;
                    w_code     = KC_EQUALS;
                    w_valid    = 1'b1;
                    w_derr     = stat.div_zero;
                    last_next  = calc_val;
                    lamp_next  = lamp_reg || (calc_val == match_reg);
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (emit)
        begin
            pend_valid_next        = 1'b1;
            pend_next.key_hit      = w_hit;
            pend_next.key_code     = w_code;
            pend_next.cleared      = w_cleared;
            pend_next.result_valid = w_valid;
            pend_next.result_value = last_next;
            pend_next.divide_error = w_derr;
            pend_next.lamp_on      = lamp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            first_reg      <= '0;
            second_reg     <= '0;
            count_reg      <= '0;
            oper_reg       <= OP_NONE;
            last_reg       <= '0;
            match_reg      <= MATCH_RESET;
            lamp_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            pend_reg       <= '0;
            out_valid_reg  <= 1'b0;
            out_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            first_reg      <= first_next;
            second_reg     <= second_next;
            count_reg      <= count_next;
            oper_reg       <= oper_next;
            last_reg       <= last_next;
            match_reg      <= match_next;
            lamp_reg       <= lamp_next;
            pend_valid_reg <= pend_valid_next;
            pend_reg       <= pend_next;
            out_valid_reg  <= out_valid_next;
            out_reg        <= out_next;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.key_hit      = out_reg.key_hit;
    assign result.key_code     = out_reg.key_code;
    assign result.cleared      = out_reg.cleared;
    assign result.result_valid = out_reg.result_valid;
    assign result.result_value = out_reg.result_value;
    assign result.divide_error = out_reg.divide_error;
    assign result.lamp_on      = out_reg.lamp_on;

endmodule

FILE: design/kfc_checker.sv
// Port-level checks on the calculator's result words, bound to the top level.
module kfc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic        key_hit,
    input logic [7:0]  key_code,
    input logic        cleared,
    input logic        result_valid,
    input logic [31:0] result_value,
    input logic        divide_error,
    input logic        lamp_on
);
    import kfc_pkg::*;

    // a stalled word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(key_code)
                                    && $stable(result_value) && $stable(lamp_on))
        else $error("result word changed while stalled");

    a_nokey: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !key_hit |-> key_code == 8'd0 && !cleared && !result_valid
                                  && !divide_error)
        else $error("flags set on a word without a key");

    a_divzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && divide_error |-> result_valid && result_value == 32'd0
                                      && key_code == KC_EQUALS)
        else $error("divide error without a zeroed equals result");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && cleared |-> result_value == 32'd0 && !result_valid
                                 && key_code == KC_CLEAR)
        else $error("clear word carries a result");

    // lamp is sticky across words
    a_lamp: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && lamp_on |=> !out_valid || lamp_on)
        else $error("lamp went dark");

endmodule

bind keypad_four_function_calculator kfc_checker u_kfc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .key_hit      (result.key_hit),
    .key_code     (result.key_code),
    .cleared      (result.cleared),
    .result_valid (result.result_valid),
    .result_value (result.result_value),
    .divide_error (result.divide_error),
    .lamp_on      (result.lamp_on)
);

FILE: tb/sv/keypad_four_function_calculator_tb.sv
// Self-checking testbench for the keypad calculator, results checked against a predictor.
module keypad_four_function_calculator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import kfc_pkg::*;

    localparam logic [7:0] KC_DIGIT0   = 8'hB0;
    localparam logic [7:0] NO_KEY      = 8'h00;  // table row drives raw column/row values
    localparam logic [3:0] ROWS_IDLE   = 4'hF;
    localparam logic [3:0] ROWS_ALL    = 4'h0;
    localparam logic [7:0] OPER_KEYS [4] = '{KC_ADD, KC_SUB, KC_MUL, KC_DIV};
    localparam int         HOLD_CYCLES = 400;
    localparam int         TAIL_CYCLES = 40;
    localparam int         PHASE_WORDS = 180;

    typedef enum int {
        DRAIN_FREE,
        DRAIN_RANDOM,
        DRAIN_SLOW
    } drain_mode_t;

    typedef struct packed {
        logic [7:0] key;
        logic [1:0] col;
        logic [3:0] rows;
        logic       fixed;
        res_word_t  want;
    } scan_row_t;

    logic clk;
    logic rst_n;

    kfc_scan_if   scan_ch ();
    kfc_result_if res_ch ();
    kfc_cfg_if    cfg_ch ();

    keypad_four_function_calculator u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .scan   (scan_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    // calculator state as the block should hold it
    logic [OPND_W-1:0] acc_first;
    logic [OPND_W-1:0] acc_second;
    logic [CNT_W-1:0]  acc_digits;
    op_t               acc_op;
    logic [RES_W-1:0]  acc_result;
    logic              acc_lamp;
    logic [RES_W-1:0]  match_q;

    res_word_t pending_results [$];
    int        fail_cnt     = 0;
    int        results_seen = 0;
    int        keys_sent    = 0;
    int        burst_left   = 1;

    // Fixed rows carry their result; the rest are checked against evaluate_scan.
    scan_row_t directed_rows [29] = '{
        // no key, then every row low: state untouched
        '{NO_KEY, 2'd0, ROWS_IDLE, 1'b1, {1'b0, NO_KEY, 1'b0, 1'b0, 32'd0, 1'b0, 1'b0}},
        '{NO_KEY, 2'd3, ROWS_ALL,  1'b1, {1'b0, NO_KEY, 1'b0, 1'b0, 32'd0, 1'b0, 1'b0}},
        // equals with no operator keeps 0; lamp stays off against the reset match of 30
        '{KC_EQUALS, 2'd0, 4'h0, 1'b1, {1'b1, KC_EQUALS, 1'b0, 1'b1, 32'd0, 1'b0, 1'b0}},
        '{KC_DIV,    2'd0, 4'h0, 1'b1, {1'b1, KC_DIV,    1'b0, 1'b0, 32'd0, 1'b0, 1'b0}},
        '{KC_EQUALS, 2'd0, 4'h0, 1'b1, {1'b1, KC_EQUALS, 1'b0, 1'b1, 32'd0, 1'b1, 1'b0}},
        // clear, then ten nines into the first operand: the last one is past the digit limit
        '{KC_CLEAR, 2'd0, 4'h0, 1'b1, {1'b1, KC_CLEAR, 1'b1, 1'b0, 32'd0, 1'b0, 1'b0}},
        '{KC_DIGIT0 + 8'd9, 2'd0, 4'h0, 1'b0, '0},
        '{KC_DIGIT0 + 8'd9, 2'd0, 4'h0, 1'b0, '0},
        '{KC_DIGIT0 + 8'd9, 2'd0, 4'h0, 1'b0, '0},
        '{KC_DIGIT0 + 8'd9, 2'd0, 4'h0, 1'b0, '0},
        '{KC_DIGIT0 + 8'd9, 2'd0, 4'h0, 1'b0, '0},
        '{KC_DIGIT0 + 8'd9, 2'd0, 4'h0, 1'b0, '0},
        '{KC_DIGIT0 + 8'd9, 2'd0, 4'h0, 1'b0, '0},
        '{KC_DIGIT0 + 8'd9, 2'd0, 4'h0, 1'b0, '0},
        '{KC_DIGIT0 + 8'd9, 2'd0, 4'h0, 1'b0, '0},
        '{KC_DIGIT0 + 8'd9, 2'd0, 4'h0, 1'b0, '0},
        '{KC_DIV,           2'd0, 4'h0, 1'b0, '0},
        '{KC_DIGIT0 + 8'd7, 2'd0, 4'h0, 1'b0, '0},
        '{KC_EQUALS,        2'd0, 4'h0, 1'b0, '0},
        // operator replaced, then a wrapping multiply
        '{KC_ADD,           2'd0, 4'h0, 1'b0, '0},
        '{KC_MUL,           2'd0, 4'h0, 1'b0, '0},
        '{KC_DIGIT0 + 8'd9, 2'd0, 4'h0, 1'b0, '0},
        '{KC_EQUALS,        2'd0, 4'h0, 1'b0, '0},
        '{KC_CLEAR, 2'd0, 4'h0, 1'b1, {1'b1, KC_CLEAR, 1'b1, 1'b0, 32'd0, 1'b0, 1'b0}},
        '{KC_SUB,   2'd0, 4'h0, 1'b1, {1'b1, KC_SUB,   1'b0, 1'b0, 32'd0, 1'b0, 1'b0}},
        '{KC_DIGIT0 + 8'd5, 2'd0, 4'h0, 1'b1,
          {1'b1, KC_DIGIT0 + 8'd5, 1'b0, 1'b0, 32'd0, 1'b0, 1'b0}},
        '{KC_EQUALS, 2'd0, 4'h0, 1'b1,
          {1'b1, KC_EQUALS, 1'b0, 1'b1, 32'hFFFF_FFFB, 1'b0, 1'b0}},
        // digits after equals extend the second operand: 0 - 50
        '{KC_DIGIT0, 2'd0, 4'h0, 1'b1,
          {1'b1, KC_DIGIT0, 1'b0, 1'b0, 32'hFFFF_FFFB, 1'b0, 1'b0}},
        '{KC_EQUALS, 2'd0, 4'h0, 1'b1,
          {1'b1, KC_EQUALS, 1'b0, 1'b1, 32'hFFFF_FFCE, 1'b0, 1'b0}}
    };

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic res_word_t evaluate_scan(input logic [1:0] col, input logic [3:0] rows);
        res_word_t        w;
        logic [3:0]       row_base;
        logic [3:0]       idx;
        logic             pressed;
        logic [RES_W-1:0] lhs;
        logic [RES_W-1:0] rhs;
        w       = '0;
        pressed = 1'b1;
        case (rows)
            4'hE:    row_base = 4'd12;
            4'hD:    row_base = 4'd8;
            4'hB:    row_base = 4'd4;
            4'h7:    row_base = 4'd0;
            default:
            begin
                row_base = 4'd0;
                pressed  = 1'b0;
            end
        endcase
        if (pressed)
        begin
            idx        = row_base + 4'(2'd3 - col);
            w.key_hit  = 1'b1;
            w.key_code = KEY_CODES[idx];
            lhs        = RES_W'(acc_first);
            rhs        = RES_W'(acc_second);
            case (w.key_code)
                KC_CLEAR:
                begin
                    w.cleared  = 1'b1;
                    acc_first  = '0;
                    acc_second = '0;
                    acc_digits = '0;
                    acc_op     = OP_NONE;
                    acc_result = '0;
                end
                KC_ADD, KC_SUB, KC_MUL, KC_DIV:
                begin
                    acc_op     = (w.key_code == KC_ADD) ? OP_ADD :
                                 (w.key_code == KC_SUB) ? OP_SUB :
                                 (w.key_code == KC_MUL) ? OP_MUL : OP_DIV;
                    acc_second = '0;
                    acc_digits = '0;
                end
                KC_EQUALS:
                begin
                    w.result_valid = 1'b1;
                    case (acc_op)
                        OP_ADD: acc_result = lhs + rhs;
                        OP_SUB: acc_result = lhs - rhs;
                        OP_MUL: acc_result = lhs * rhs;
                        OP_DIV:
                        begin
                            // both operands stay below 2^30, so unsigned divide is exact
                            if (rhs == '0)
                            begin
                                w.divide_error = 1'b1;
                                acc_result     = '0;
                            end
                            else
                                acc_result = lhs / rhs;
                        end
                        default: ;
                    endcase
                    if (acc_result == match_q)
                        acc_lamp = 1'b1;
                end
                default:
                begin
                    if (acc_digits < KFC_MAX_DIGITS)
                    begin
                        if (acc_op == OP_NONE)
                            acc_first = OPND_W'(acc_first * 10 + w.key_code[3:0]);
                        else
                            acc_second = OPND_W'(acc_second * 10 + w.key_code[3:0]);
                        acc_digits = acc_digits + 1'b1;
                    end
                end
            endcase
        end
        w.result_value = acc_result;
        w.lamp_on      = acc_lamp;
        return w;
    endfunction

    function automatic void locate_key(input logic [7:0] code, output logic [1:0] col,
                                       output logic [3:0] rows);
        col  = '0;
        rows = ROWS_IDLE;
        for (int k = 0; k < 16; k++)
        begin
            if (KEY_CODES[k] == code)
            begin
                col  = 2'd3 - 2'(k % 4);
                rows = ~(4'b0001 << (3 - k / 4));
            end
        end
    endfunction

    function automatic int digit_run();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 7)
            return $urandom_range(1, 3);
        if (pick < 9)
            return $urandom_range(4, KFC_MAX_DIGITS);
        return $urandom_range(KFC_MAX_DIGITS + 1, KFC_MAX_DIGITS + 2);
    endfunction

    // Offers one scan word, waits for it to be taken, then maybe idles between bursts.
    task automatic send_scan(input logic [1:0] col, input logic [3:0] rows,
                             input logic use_fixed, input res_word_t fixed_word);
        res_word_t predicted;
        int        gap;
        scan_ch.valid     <= 1'b1;
        scan_ch.column    <= col;
        scan_ch.row_lines <= rows;
        @(posedge clk);
        while (!scan_ch.ready)
            @(posedge clk);
        predicted = evaluate_scan(col, rows);
        pending_results.push_back(use_fixed ? fixed_word : predicted);
        burst_left--;
        if (burst_left <= 0)
        begin
            gap        = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(0, 10);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
            if (gap > 0)
            begin
                scan_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic press_key(input logic [7:0] code);
        logic [1:0] col;
        logic [3:0] rows;
        locate_key(code, col, rows);
        send_scan(col, rows, 1'b0, '0);
        keys_sent++;
    endtask

    task automatic send_noise();
        logic [3:0] rows;
        rows = 4'($urandom_range(0, 15));
        while ($countones(~rows) == 1)
            rows = 4'($urandom_range(0, 15));
        send_scan(2'($urandom_range(0, 3)), rows, 1'b0, '0);
    endtask

    task automatic enter_number(input int len);
        repeat (len) press_key(KC_DIGIT0 + 8'($urandom_range(0, 9)));
    endtask

    task automatic enter_calculation();
        if ($urandom_range(0, 9) < 6)
            press_key(KC_CLEAR);
        enter_number(digit_run());
        if ($urandom_range(0, 4) == 0)
            press_key(OPER_KEYS[$urandom_range(0, 3)]);
        press_key(OPER_KEYS[$urandom_range(0, 3)]);
        enter_number(($urandom_range(0, 9) == 0) ? 0 : digit_run());
        press_key(KC_EQUALS);
        if ($urandom_range(0, 3) == 0)
        begin
            enter_number($urandom_range(1, 2));
            press_key(KC_EQUALS);
        end
    endtask

    task automatic run_random(input int word_target);
        int stop_at;
        int pick;
        stop_at = keys_sent + word_target;
        while (keys_sent < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 80)
                enter_calculation();
            else if (pick < 90)
                repeat ($urandom_range(1, 4)) send_noise();
            else
                repeat ($urandom_range(1, 6)) press_key(KEY_CODES[$urandom_range(0, 15)]);
        end
    endtask

    // Only written once every expected word has drained, so the block is idle.
    task automatic write_match(input logic [RES_W-1:0] value);
        scan_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        match_q = value;
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_cnt++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        res_word_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $error("result word with no scan word pending");
                fail_cnt++;
            end
            else
            begin
                want = pending_results.pop_front();
                compare_field("key_hit",      want.key_hit,      res_ch.key_hit);
                compare_field("key_code",     want.key_code,     res_ch.key_code);
                compare_field("cleared",      want.cleared,      res_ch.cleared);
                compare_field("result_valid", want.result_valid, res_ch.result_valid);
                compare_field("result_value", want.result_value, res_ch.result_value);
                compare_field("divide_error", want.divide_error, res_ch.divide_error);
                compare_field("lamp_on",      want.lamp_on,      res_ch.lamp_on);
            end
        end
    end

    // Output backpressure: stretches of free, random and slow draining, plus one long hold.
    initial
    begin : result_drain
        drain_mode_t mode;
        int          stretch;
        bit          held;
        mode    = DRAIN_FREE;
        stretch = 0;
        held    = 1'b0;
        res_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!held && results_seen >= 200)
            begin
                held = 1'b1;
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if (stretch == 0)
            begin
                mode    = drain_mode_t'($urandom_range(0, 2));
                stretch = $urandom_range(20, 150);
            end
            stretch--;
            case (mode)
                DRAIN_FREE:   res_ch.ready <= 1'b1;
                DRAIN_RANDOM: res_ch.ready <= 1'($urandom_range(0, 1));
                default:      res_ch.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    initial
    begin : stimulus
        logic [1:0]       col;
        logic [3:0]       rows;
        logic [RES_W-1:0] phase_match [4];
        rst_n             <= 1'b0;
        scan_ch.valid     <= 1'b0;
        scan_ch.column    <= '0;
        scan_ch.row_lines <= ROWS_IDLE;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.data       <= '0;
        acc_first  = '0;
        acc_second = '0;
        acc_digits = '0;
        acc_op     = OP_NONE;
        acc_result = '0;
        acc_lamp   = 1'b0;
        match_q    = MATCH_RESET;
        // zero goes last: the lamp is sticky, so the unreachable values come first
        phase_match[0] = 32'h8000_0000;
        phase_match[1] = 32'h7FFF_FFFF;
        phase_match[2] = $urandom;
        phase_match[3] = 32'd0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            col  = directed_rows[i].col;
            rows = directed_rows[i].rows;
            if (directed_rows[i].key != NO_KEY)
                locate_key(directed_rows[i].key, col, rows);
            send_scan(col, rows, directed_rows[i].fixed, directed_rows[i].want);
        end

        foreach (phase_match[p])
        begin
            write_match(phase_match[p]);
            run_random(PHASE_WORDS);
        end

        scan_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_cnt == 0)
            $display("** keypad_four_function_calculator: PASSED **");
        else
            $display("** keypad_four_function_calculator: FAILED **");
        $finish;
    end

    initial
    begin : watchdog
        #5_000_000;
        $display("** keypad_four_function_calculator: FAILED **");
        $finish;
    end

endmodule

FILE: filelist.f
design/kfc_pkg.sv
design/kfc_intf.sv
design/kfc_keydec.sv
design/kfc_alu.sv
design/keypad_four_function_calculator.sv
design/kfc_checker.sv
tb/sv/keypad_four_function_calculator_tb.sv
